[rtl/aclk_pkg.sv]
// shared types, constants and codes of the animation clock block
package aclk_pkg;

   // time word and the wider signed window word
   localparam int TIME_BITS         = 24;
   localparam int WIN_BITS          = TIME_BITS + 3;
   localparam int DIV_BITS          = TIME_BITS + 1;
   localparam int MAX_TRIGGERS_DEF  = 16;
   localparam int SLOT_BITS         = 4;
   localparam int TCOUNT_BITS       = 5;
   localparam int CSR_INDEX_BITS    = 2;

   typedef logic signed [WIN_BITS-1:0] win_type;

   // request action codes
   typedef enum logic [1:0] {
      ACT_ADVANCE = 2'd0,
      ACT_SET     = 2'd1,
      ACT_WRITE   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOPED     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIG_COUNT = 2'd2;

   // result kinds
   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_TRIGGER = 1'b1;

   typedef struct packed {
      logic [1:0]                  action;
      logic signed [TIME_BITS-1:0] delta;
      logic [TIME_BITS-1:0]        time_value;
      logic [SLOT_BITS-1:0]        trigger_slot;
   } aclk_req_type;

   typedef struct packed {
      logic                 kind;
      logic [TIME_BITS-1:0] play_time;
      logic                 finished;
      logic [SLOT_BITS-1:0] fired_index;
      logic [TIME_BITS-1:0] fired_time;
      logic                 last;
   } aclk_rsp_type;

   // control of the shared remainder unit
   typedef struct packed {
      logic                 start;
      logic                 negate;
      logic [DIV_BITS-1:0]  dividend;
      logic [TIME_BITS-1:0] divisor;
   } aclk_mod_req_type;

   typedef struct packed {
      logic                 done;
      logic [TIME_BITS-1:0] remainder;
   } aclk_mod_rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MODT,
      ST_WINDOW,
      ST_ORDER,
      ST_READ,
      ST_FETCH,
      ST_MODF,
      ST_CHECK,
      ST_FLUSH
   } state_type;

endpackage

[rtl/aclk_ram.sv]
// generic single-port-write ram with registered read
module aclk_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aclk_mod_unit.sv]
// bit-serial restoring remainder unit, one quotient bit per cycle
module aclk_mod_unit
   import aclk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  aclk_mod_req_type mod_req,
   output aclk_mod_rsp_type mod_rsp
);

   localparam int COUNT_BITS = $clog2(DIV_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]   dvd_ff, dvd_in;
   logic [TIME_BITS-1:0]  div_ff, div_in;
   logic [TIME_BITS:0]    trial;

   // load on start, then one restoring step, or the sign fix once all bits are in
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      trial    = {rem_ff, dvd_ff[DIV_BITS-1]};
      if (mod_req.start) begin
         busy_in  = 1'b1;
         neg_in   = mod_req.negate;
         count_in = COUNT_BITS'(DIV_BITS);
         rem_in   = '0;
         dvd_in   = mod_req.dividend;
         div_in   = mod_req.divisor;
      end else if (busy_ff) begin
         if (count_ff != '0) begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = TIME_BITS'(trial - {1'b0, div_ff});
            end else begin
               rem_in = trial[TIME_BITS-1:0];
            end
            dvd_in   = {dvd_ff[DIV_BITS-2:0], 1'b0};
            count_in = count_ff - 1'b1;
         end else begin
            // negative dividend: fold the remainder back into 0..divisor-1
            if (neg_ff && rem_ff != '0) begin
               rem_in = div_ff - rem_ff;
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      div_ff   <= div_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

[rtl/anim_clock_with_triggers.sv]
// animation playback clock with trigger table, top level and sequencer
//
// Requests come in on req_valid/req_ready/req_data: advance by a signed
// delta, set the time, or write one trigger table entry. Every request gives
// one status result on rsp_valid/rsp_ready/rsp_data, followed for an advance
// by one result per trigger time the step crossed; the final one has last set.
// Length, loop mode and trigger count are written on csr_we/csr_index/
// csr_wdata; the user must write them only while the block is idle, which the
// block itself leaves unchecked. One request is worked on at a time and
// req_ready is low until its last result sits in the output register. Set,
// write and no-op requests pass decode and flush. An advance passes decode,
// a time wrap if a looped step wraps, window, order, then read, fetch, a
// trigger wrap if a looped step wrapped and check per trigger in use, then
// flush; the time and each trigger time wrap in one shared bit-serial unit.
// A stalled receiver holds the sequencer at the next result it wants to hand
// over; the output register keeps its item until rsp_ready.
// Reset clears the clock time, csr registers, state and output valid flag;
// the trigger table is not cleared and must be written before it is scanned.
module anim_clock_with_triggers
   import aclk_pkg::*;
#(
   parameter int MAX_TRIGGERS = MAX_TRIGGERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  aclk_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output aclk_rsp_type              rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]      csr_wdata
);

   localparam int ADDR_BITS = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_TRIGGERS + 1);

   state_type state_ff, state_in;

   logic [TIME_BITS-1:0]   length_ff, length_in;
   logic                   looped_ff, looped_in;
   logic [TCOUNT_BITS-1:0] tcount_ff, tcount_in;
   logic [TIME_BITS-1:0]   clock_ff, clock_in;

   aclk_req_type         req_ff, req_in;
   win_type              t_ff, t_in;
   win_type              lo_ff, lo_in;
   win_type              hi_ff, hi_in;
   logic                 fin_ff, fin_in;
   logic                 wrap_ff, wrap_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [TIME_BITS-1:0] f_ff, f_in;
   logic [TIME_BITS-1:0] ftime_ff, ftime_in;
   aclk_rsp_type         pend_ff, pend_in;
   aclk_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   aclk_mod_req_type     mod_req;
   aclk_mod_rsp_type     mod_rsp;
   logic                 ram_we;
   logic [TIME_BITS-1:0] ram_rdata;

   win_type              old_w, len_w, d_w, t_sum, t_abs, f_w;
   logic                 d_pos, adv_go, slot_ok, hit, out_free, push, push_last;
   logic [CNT_BITS-1:0]  cnt_eff;
   logic [CNT_BITS-1:0]  idx_next;
   logic [TIME_BITS-1:0] now;
   logic                 fin_clamp;

   function automatic aclk_rsp_type status_rsp(logic [TIME_BITS-1:0] pt, logic fin);
      aclk_rsp_type r;
      r.kind        = KIND_STATUS;
      r.play_time   = pt;
      r.finished    = fin;
      r.fired_index = '0;
      r.fired_time  = '0;
      r.last        = 1'b0;
      return r;
   endfunction

   // common views of the operands
   always_comb begin
      old_w    = {{(WIN_BITS-TIME_BITS){1'b0}}, clock_ff};
      len_w    = {{(WIN_BITS-TIME_BITS){1'b0}}, length_ff};
      d_w      = {{(WIN_BITS-TIME_BITS){req_ff.delta[TIME_BITS-1]}}, req_ff.delta};
      f_w      = {{(WIN_BITS-TIME_BITS){1'b0}}, f_ff};
      t_sum    = old_w + d_w;
      t_abs    = t_sum[WIN_BITS-1] ? -t_sum : t_sum;
      d_pos    = !req_ff.delta[TIME_BITS-1];
      adv_go   = (req_ff.delta != '0) && (length_ff != '0);
      slot_ok  = 32'(req_ff.trigger_slot) < MAX_TRIGGERS;
      cnt_eff  = (32'(tcount_ff) > MAX_TRIGGERS) ? CNT_BITS'(MAX_TRIGGERS)
                                                 : CNT_BITS'(tcount_ff);
      idx_next = idx_ff + 1'b1;
      hit      = (lo_ff <= f_w) && (hi_ff > f_w);
      out_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_IDLE);
   end

   // single-shot clamp of the new time, or its low bits when looped, and its end flag
   always_comb begin
      if (t_ff[WIN_BITS-1]) begin
         now = '0;
      end else if (t_ff > len_w) begin
         now = length_ff;
      end else begin
         now = t_ff[TIME_BITS-1:0];
      end
      if (looped_ff) begin
         now = t_ff[TIME_BITS-1:0];
      end
      if (d_pos) begin
         fin_clamp = (old_w < len_w) && (t_ff >= len_w);
      end else begin
         fin_clamp = (clock_ff != '0) && (t_ff[WIN_BITS-1] || t_ff == '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FLUSH;
            if (req_ff.action == ACT_ADVANCE && adv_go) begin
               if (looped_ff && (t_sum >= len_w || t_sum[WIN_BITS-1])) begin
                  state_in = ST_MODT;
               end else begin
                  state_in = ST_WINDOW;
               end
            end
         end
         ST_MODT: begin
            if (mod_rsp.done) begin
               state_in = ST_WINDOW;
            end
         end
         ST_WINDOW: state_in = ST_ORDER;
         ST_ORDER: begin
            state_in = (cnt_eff == '0) ? ST_FLUSH : ST_READ;
         end
         ST_READ:  state_in = ST_FETCH;
         ST_FETCH: begin
            state_in = (looped_ff && wrap_ff) ? ST_MODF : ST_CHECK;
         end
         ST_MODF: begin
            if (mod_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!hit || out_free) begin
               state_in = (idx_next == cnt_eff) ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output control
   always_comb begin
      req_in    = req_ff;
      clock_in  = clock_ff;
      t_in      = t_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      fin_in    = fin_ff;
      wrap_in   = wrap_ff;
      idx_in    = idx_ff;
      f_in      = f_ff;
      ftime_in  = ftime_ff;
      pend_in   = pend_ff;
      ram_we    = 1'b0;
      push      = 1'b0;
      push_last = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.negate   = 1'b0;
      mod_req.dividend = t_abs[DIV_BITS-1:0];
      mod_req.divisor  = length_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ST_DECODE: begin
            fin_in  = 1'b0;
            pend_in = status_rsp(clock_ff, 1'b0);
            case (req_ff.action)
               ACT_SET: begin
                  clock_in = (req_ff.time_value > length_ff) ? length_ff
                                                             : req_ff.time_value;
                  pend_in  = status_rsp(clock_in, 1'b0);
               end
               ACT_WRITE: begin
                  ram_we = slot_ok;
               end
               ACT_ADVANCE: begin
                  if (adv_go) begin
                     t_in = t_sum;
                     if (looped_ff && (t_sum >= len_w || t_sum[WIN_BITS-1])) begin
                        mod_req.start  = 1'b1;
                        mod_req.negate = t_sum[WIN_BITS-1];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MODT: begin
            if (mod_rsp.done) begin
               t_in   = {{(WIN_BITS-TIME_BITS){1'b0}}, mod_rsp.remainder};
               fin_in = 1'b1;
            end
         end
         ST_WINDOW: begin
            // new time, end flag, then the crossed window with wrap shift
            clock_in = now;
            if (!looped_ff) begin
               fin_in = fin_clamp;
            end
            pend_in = status_rsp(now, looped_ff ? fin_ff : fin_clamp);
            lo_in   = old_w;
            hi_in   = t_ff;
            wrap_in = 1'b0;
            if (d_pos && old_w > t_ff) begin
               lo_in   = old_w - len_w;
               wrap_in = 1'b1;
            end
            if (!d_pos && t_ff > old_w) begin
               hi_in   = t_ff - len_w;
               wrap_in = 1'b1;
            end
         end
         ST_ORDER: begin
            if (lo_ff > hi_ff) begin
               lo_in = hi_ff;
               hi_in = lo_ff;
            end
            idx_in = '0;
         end
         ST_FETCH: begin
            ftime_in = ram_rdata;
            f_in     = ram_rdata;
            if (looped_ff && wrap_ff) begin
               mod_req.start    = 1'b1;
               mod_req.dividend = {{(DIV_BITS-TIME_BITS){1'b0}}, ram_rdata};
            end
         end
         ST_MODF: begin
            if (mod_rsp.done) begin
               f_in = mod_rsp.remainder;
            end
         end
         ST_CHECK: begin
            // a hit sends the held result on and takes its place
            if (!hit || out_free) begin
               idx_in = idx_next;
            end
            if (hit && out_free) begin
               push                = 1'b1;
               pend_in.kind        = KIND_TRIGGER;
               pend_in.play_time   = clock_ff;
               pend_in.finished    = fin_ff;
               pend_in.fired_index = SLOT_BITS'(idx_ff);
               pend_in.fired_time  = ftime_ff;
               pend_in.last        = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (push) begin
         rsp_in       = pend_ff;
         rsp_in.last  = push_last;
         rsp_valid_in = 1'b1;
      end
   end

   // configuration writes
   always_comb begin
      length_in = length_ff;
      looped_in = looped_ff;
      tcount_in = tcount_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LENGTH:     length_in = csr_wdata;
            CSR_LOOPED:     looped_in = csr_wdata[0];
            CSR_TRIG_COUNT: tcount_in = csr_wdata[TCOUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         looped_ff    <= 1'b0;
         tcount_ff    <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         looped_ff    <= looped_in;
         tcount_ff    <= tcount_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      t_ff     <= t_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      fin_ff   <= fin_in;
      wrap_ff  <= wrap_in;
      idx_ff   <= idx_in;
      f_ff     <= f_in;
      ftime_ff <= ftime_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // trigger time table
   aclk_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_TRIGGERS)
   ) u_trigger_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_BITS'(req_ff.trigger_slot)),
      .wr_data (req_ff.time_value),
      .rd_addr (idx_ff[ADDR_BITS-1:0]),
      .rd_data (ram_rdata)
   );

   // shared remainder unit for time and trigger wrap
   aclk_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

endmodule
